// ===== hdl/res_pkg.sv =====
// Shared types and constants for the recent echo suppression table.
// Used by res_match and recent_echo_suppression_table; no other dependencies.
package res_pkg;

    // Item opcodes carried in the input tuser field.
    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_SET    = 2'd1,
        OP_RESET  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Destination mapping constants.
    localparam logic [7:0] DST_FLAG   = 8'h40;
    localparam logic [7:0] BCAST_NODE = 8'h1F;

    // Configuration register map.
    localparam int unsigned    APB_ADDR_W   = 3;
    localparam logic [7:0]     WINDOW_RESET = 8'd10;
    localparam logic           REG_WINDOW   = 1'b0;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;

    // One stored bit report.
    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  state;
        logic [7:0]  bitn;
        logic [7:0]  node;
    } entry_t;

    // The command being checked against the table.
    typedef struct packed {
        logic [31:0] now;
        logic [7:0]  want;
        logic [7:0]  bitn;
        logic [7:0]  node;
    } query_t;

endpackage

// ===== hdl/res_match.sv =====
// Compare unit shared by every step of the table scan.
// Depends on res_pkg for the entry and query structs.
module res_match (
    input  res_pkg::entry_t query_entry,
    input  logic            entry_valid,
    input  res_pkg::query_t query,
    input  logic [7:0]      window,
    output logic            hit
);
    import res_pkg::*;

    logic [32:0] expiry;
    logic        recent;
    logic        same_cmd;

    // An entry is recent while its time plus the window lies past now, with no wrap.
    assign expiry   = {1'b0, query_entry.stamp} + {25'd0, window};
    assign recent   = expiry > {1'b0, query.now};

    // Same node, same bit and already in the commanded state.
    assign same_cmd = (query_entry.node == query.node) && (query_entry.bitn == query.bitn)
                      && (query_entry.state == query.want);

    assign hit = entry_valid && recent && same_cmd;

endmodule

// ===== hdl/recent_echo_suppression_table.sv =====
// Top level of the recent echo suppression table: ring of bit reports plus scan sequencer.
// Depends on res_pkg and instantiates res_match.
//
// Usage: the s_ stream carries one request per item, opcode in s_tuser, the report or
// command fields in s_tdata. Opcode 0 stores a report in the next ring slot, opcodes 1
// and 2 check a set or reset command against all stored reports, opcode 3 does nothing.
// Each request yields exactly one result on the m_ stream: send_allowed and radio_dest.
// A record or no-op request goes from idle straight to the done state, which registers
// the result once the output is free; a check request first scans the ring and then
// passes the flush state. The check is slower because the one compare unit visits one
// ring entry per cycle through the registered read port of the entry memory. s_tready
// is high only while the sequencer is idle, so one request is in work at a time.
// The result register lets the next request be accepted while a result still waits;
// if the receiver stalls, the following result holds the sequencer until m_tready.
// Reset (aresetn low, synchronous) clears all valid bits, the write pointer, the
// output and sets window_seconds to 10; entry contents are not cleared.
// The APB port holds window_seconds at byte address 0; pready is always high.
module recent_echo_suppression_table #(
    parameter int unsigned DEPTH = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [res_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // node_id[7:0], dest_byte[15:8], bit_number[23:16], bit_state[31:24], now_seconds[63:32]
    input  logic [res_pkg::S_TDATA_W-1:0]      s_tdata,
    // op[1:0]
    input  logic [res_pkg::S_TUSER_W-1:0]      s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // send_allowed[0], radio_dest[8:1], zero[15:9]
    output logic [res_pkg::M_TDATA_W-1:0]      m_tdata
);
    import res_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [7:0]         window_reg;
    logic [AW-1:0]      wp_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               rd_vld_reg;
    logic               rd_ent_vld_reg;
    entry_t             rd_data_reg;
    query_t             query_reg;
    logic [7:0]         rdest_reg;
    logic               check_reg;
    logic               hit_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    entry_t             mem [DEPTH];

    op_t                in_op;
    entry_t             in_entry;
    logic [7:0]         in_dest;
    logic               s_acc;
    logic               cfg_wr;
    logic               out_free;
    logic               step_hit;

    // Input field unpacking.
    assign in_op          = op_t'(s_tuser[1:0]);
    assign in_entry.node  = s_tdata[7:0];
    assign in_dest        = s_tdata[15:8];
    assign in_entry.bitn  = s_tdata[23:16];
    assign in_entry.state = s_tdata[31:24];
    assign in_entry.stamp = s_tdata[63:32];

    // No request is taken while reset is held.
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration register access.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
    assign prdata = (paddr[2] == REG_WINDOW) ? {24'd0, window_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr) begin
            window_reg <= pwdata[7:0];
        end
    end

    // Entry memory: written by record requests, read one entry per scan cycle.
    always_ff @(posedge aclk) begin
        if (s_acc && (in_op == OP_RECORD)) begin
            mem[wp_reg] <= in_entry;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr_reg];
    end

    // Shared compare unit working on the registered read data.
    res_match u_match (
        .query_entry (rd_data_reg),
        .entry_valid (rd_ent_vld_reg && rd_vld_reg),
        .query       (query_reg),
        .window      (window_reg),
        .hit         (step_hit)
    );

    // Query capture and destination mapping at acceptance.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            query_reg.now  <= in_entry.stamp;
            query_reg.bitn <= in_entry.bitn;
            query_reg.want <= (in_op == OP_SET) ? 8'd1 : 8'd0;
            if (in_dest < BCAST_NODE) begin
                query_reg.node <= in_dest;
                rdest_reg      <= in_dest | DST_FLAG;
            end else begin
                query_reg.node <= BCAST_NODE;
                rdest_reg      <= BCAST_NODE;
            end
        end
    end

    // Sequencer, ring pointer, valid bits and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            valid_reg      <= '0;
            rd_addr_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            rd_ent_vld_reg <= 1'b0;
            check_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end else begin
            rd_ent_vld_reg <= valid_reg[rd_addr_reg];
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (rd_vld_reg && step_hit) begin
                hit_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    rd_vld_reg <= 1'b0;
                    if (s_acc) begin
                        rd_addr_reg <= '0;
                        hit_reg     <= 1'b0;
                        check_reg   <= (in_op == OP_SET) || (in_op == OP_RESET);
                        if ((in_op == OP_SET) || (in_op == OP_RESET)) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                        if (in_op == OP_RECORD) begin
                            valid_reg[wp_reg] <= 1'b1;
                            wp_reg <= (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    rd_vld_reg <= 1'b1;
                    if (rd_addr_reg == LAST_IDX) begin
                        state_reg <= ST_FLUSH;
                    end else begin
                        rd_addr_reg <= rd_addr_reg + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    rd_vld_reg <= 1'b0;
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    rd_vld_reg <= 1'b0;
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (check_reg) begin
                            m_tdata_reg <= {7'd0, rdest_reg, !hit_reg};
                        end else begin
                            m_tdata_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The ring pointer never leaves the table.
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= LAST_IDX)
        else $error("write pointer out of range");

    // A record request marks its slot valid.
    a_rec_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (in_op == OP_RECORD)) |=> valid_reg[$past(wp_reg)])
        else $error("record request did not set its valid bit");

    // Record and no-op requests always produce an all-zero result.
    a_rec_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && !check_reg) |=> (m_tvalid && m_tdata == '0))
        else $error("non-check result is not zero");

    // A scan visits only addresses inside the table.
    a_scan_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_addr_reg <= LAST_IDX))
        else $error("scan address out of range");

    // The compare pipeline is empty whenever a new request may enter.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> !rd_vld_reg)
        else $error("compare pipeline busy after scan");

endmodule
